// ===== sv/cantp_pkg.sv =====
// Shared types and constants for the CAN transport receive reassembly block.
package cantp_pkg;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_FLOW = 2'd1;
    localparam logic [1:0] KIND_WORD = 2'd2;

    localparam logic [1:0] FC_CONTINUE = 2'd0;
    localparam logic [1:0] FC_OVERFLOW = 2'd2;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    localparam logic [1:0] CFG_RESPONSE_ID = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;
    localparam logic [1:0] CFG_SEPARATION = 2'd2;

    localparam logic [10:0] RESPONSE_ID_RST = 11'h7E8;
    localparam logic [7:0] BLOCK_SIZE_RST = 8'd64;
    localparam logic [7:0] SEPARATION_RST = 8'd0;

    localparam logic [11:0] MIN_FF_LEN = 12'd8;
    localparam logic [3:0] SF_MAX_LEN = 4'd7;
    localparam logic [2:0] CF_MAX_BYTES = 3'd7;
    localparam logic [2:0] FF_BYTES = 3'd6;
    localparam logic [2:0] FF_FIRST_BYTE = 3'd2;
    localparam logic [2:0] CF_FIRST_BYTE = 3'd1;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_SF,
        CLS_FF,
        CLS_FF_OVF,
        CLS_CF
    } cantp_class_t;

    typedef enum logic [1:0] {
        SEL_SF,
        SEL_FC_CONT,
        SEL_FC_OVF,
        SEL_WORD
    } cantp_sel_t;

    typedef struct packed {
        logic         frame_load;
        logic         ff_start;
        logic         cf_start;
        logic         store_step;
        logic         close;
        logic         rd_issue;
        logic         rd_capture;
        logic         out_load;
        cantp_sel_t   out_sel;
    } cantp_cmd_t;

    typedef struct packed {
        cantp_class_t cls;
        logic         left_zero;
        logic         complete;
        logic         word_end;
        logic         msg_end;
        logic         out_free;
    } cantp_stat_t;

endpackage

// ===== sv/can_transport_rx_reassembly_core.sv =====
// Top level of the CAN transport receive reassembly block.
// One frame is taken at a time; a frame beat is accepted only while the controller is idle.
// Single frame or overflow: the frame is decoded, then the result is loaded once the output register is free.
// First frame: 6 store writes, then a flow-control continue result; consecutive frame: one store write per byte.
// Completion reads bytes back one at a time (issue, then capture) through the single byte-wide store port.
// Reset clears control, session state and out_valid and loads config defaults; store and data registers are not reset.
module can_transport_rx_reassembly_core #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte0,
    input  logic [7:0]  byte1,
    input  logic [7:0]  byte2,
    input  logic [7:0]  byte3,
    input  logic [7:0]  byte4,
    input  logic [7:0]  byte5,
    input  logic [7:0]  byte6,
    input  logic [7:0]  byte7,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [63:0] data_word,
    output logic [3:0]  valid_bytes,
    output logic [9:0]  message_length,
    output logic        last,
    output logic [10:0] tx_id,
    output logic [1:0]  fc_status,
    output logic [7:0]  fc_block_size,
    output logic [7:0]  fc_separation
);
    import cantp_pkg::*;

    cantp_cmd_t  cmd;
    cantp_stat_t stat;

    assign cfg_ready = 1'b1;

    cantp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cantp_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte0          (byte0),
        .byte1          (byte1),
        .byte2          (byte2),
        .byte3          (byte3),
        .byte4          (byte4),
        .byte5          (byte5),
        .byte6          (byte6),
        .byte7          (byte7),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .kind           (kind),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .message_length (message_length),
        .last           (last),
        .tx_id          (tx_id),
        .fc_status      (fc_status),
        .fc_block_size  (fc_block_size),
        .fc_separation  (fc_separation)
    );

endmodule

// ===== sv/cantp_ctrl.sv =====
// Controller state machine sequencing decode, byte storage and result delivery.
module cantp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output cantp_pkg::cantp_cmd_t  cmd,
    input  cantp_pkg::cantp_stat_t stat
);
    import cantp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STORE_FF,
        ST_STORE_CF,
        ST_CHECK,
        ST_READ,
        ST_CAPT,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    cantp_sel_t sel_reg;
    cantp_sel_t sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.out_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.frame_load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.cls)
                    CLS_SF:
                    begin
                        sel_next = SEL_SF;
                        state_next = ST_EMIT;
                    end
                    CLS_FF_OVF:
                    begin
                        sel_next = SEL_FC_OVF;
                        state_next = ST_EMIT;
                    end
                    CLS_FF:
                    begin
                        cmd.ff_start = 1'b1;
                        state_next = ST_STORE_FF;
                    end
                    CLS_CF:
                    begin
                        cmd.cf_start = 1'b1;
                        state_next = ST_STORE_CF;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_STORE_FF:
            begin
                if (stat.left_zero)
                begin
                    sel_next = SEL_FC_CONT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.store_step = 1'b1;
                end
            end
            ST_STORE_CF:
            begin
                if (stat.left_zero)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.store_step = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (stat.complete)
                begin
                    cmd.close = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                cmd.rd_capture = 1'b1;
                if (stat.word_end)
                begin
                    sel_next = SEL_WORD;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sel_reg == SEL_WORD && !stat.msg_end)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg <= SEL_SF;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== sv/cantp_datapath.sv =====
// Datapath: frame register, session counters, byte store, word assembly and result register.
module cantp_datapath #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             byte0,
    input  logic [7:0]             byte1,
    input  logic [7:0]             byte2,
    input  logic [7:0]             byte3,
    input  logic [7:0]             byte4,
    input  logic [7:0]             byte5,
    input  logic [7:0]             byte6,
    input  logic [7:0]             byte7,
    input  logic                   cfg_valid,
    input  logic [1:0]             cfg_index,
    input  logic [10:0]            cfg_data,
    input  cantp_pkg::cantp_cmd_t  cmd,
    output cantp_pkg::cantp_stat_t stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [1:0]             kind,
    output logic [63:0]            data_word,
    output logic [3:0]             valid_bytes,
    output logic [9:0]             message_length,
    output logic                   last,
    output logic [10:0]            tx_id,
    output logic [1:0]             fc_status,
    output logic [7:0]             fc_block_size,
    output logic [7:0]             fc_separation
);
    import cantp_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [11:0] BUF_LEN = 12'(BUFFER_BYTES);

    logic [7:0]  store_mem [0:BUFFER_BYTES-1];

    logic [63:0] frame_reg;
    logic [9:0]  len_reg;
    logic [9:0]  count_reg;
    logic [3:0]  seq_reg;
    logic        active_reg;
    logic [2:0]  left_reg;
    logic [2:0]  src_reg;
    logic [9:0]  rd_ptr_reg;
    logic [3:0]  wcnt_reg;
    logic [63:0] asm_reg;
    logic [7:0]  rd_data_reg;
    logic [10:0] response_id_reg;
    logic [7:0]  block_size_reg;
    logic [7:0]  separation_reg;
    logic        out_valid_reg;

    logic [3:0]  ftype;
    logic [3:0]  low;
    logic [11:0] ff_len;
    logic [9:0]  remain;
    logic [2:0]  cf_n;
    logic [9:0]  rd_ptr_inc;
    logic [63:0] sf_word;
    cantp_class_t cls;

    assign ftype = frame_reg[7:4];
    assign low = frame_reg[3:0];
    assign ff_len = {low, frame_reg[15:8]};
    assign remain = len_reg - count_reg;
    assign cf_n = (remain > 10'(CF_MAX_BYTES)) ? CF_MAX_BYTES : remain[2:0];
    assign rd_ptr_inc = rd_ptr_reg + 10'd1;

    always_comb
    begin
        priority if (ftype == FT_SINGLE)
        begin
            cls = (low != 4'd0 && low <= SF_MAX_LEN) ? CLS_SF : CLS_IGNORE;
        end
        else if (ftype == FT_FIRST)
        begin
            priority if (ff_len < MIN_FF_LEN)
                cls = CLS_IGNORE;
            else if (ff_len > BUF_LEN)
                cls = CLS_FF_OVF;
            else
                cls = CLS_FF;
        end
        else if (ftype == FT_CONSEC)
        begin
            cls = (active_reg && low == seq_reg) ? CLS_CF : CLS_IGNORE;
        end
        else
        begin
            cls = CLS_IGNORE;
        end
    end

    always_comb
    begin
        sf_word = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (4'(i) < low)
                sf_word[8*i +: 8] = frame_reg[8*(i+1) +: 8];
        end
    end

    assign stat.cls = cls;
    assign stat.left_zero = (left_reg == 3'd0);
    assign stat.complete = (count_reg >= len_reg);
    assign stat.word_end = (wcnt_reg[2:0] == 3'd7) || (rd_ptr_inc == len_reg);
    assign stat.msg_end = (rd_ptr_reg == len_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            count_reg <= '0;
            seq_reg <= '0;
            active_reg <= 1'b0;
            left_reg <= '0;
            src_reg <= '0;
            rd_ptr_reg <= '0;
            wcnt_reg <= '0;
            response_id_reg <= RESPONSE_ID_RST;
            block_size_reg <= BLOCK_SIZE_RST;
            separation_reg <= SEPARATION_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_RESPONSE_ID: response_id_reg <= cfg_data;
                    CFG_BLOCK_SIZE:  block_size_reg <= cfg_data[7:0];
                    CFG_SEPARATION:  separation_reg <= cfg_data[7:0];
                    default:         ;
                endcase
            end
            if (cmd.ff_start)
            begin
                len_reg <= ff_len[9:0];
                count_reg <= '0;
                seq_reg <= 4'd1;
                active_reg <= 1'b1;
                left_reg <= FF_BYTES;
                src_reg <= FF_FIRST_BYTE;
            end
            if (cmd.cf_start)
            begin
                left_reg <= cf_n;
                src_reg <= CF_FIRST_BYTE;
                seq_reg <= seq_reg + 4'd1;
            end
            if (cmd.store_step)
            begin
                count_reg <= count_reg + 10'd1;
                left_reg <= left_reg - 3'd1;
                src_reg <= src_reg + 3'd1;
            end
            if (cmd.close)
            begin
                active_reg <= 1'b0;
                rd_ptr_reg <= '0;
                wcnt_reg <= '0;
            end
            if (cmd.rd_capture)
            begin
                rd_ptr_reg <= rd_ptr_inc;
                wcnt_reg <= wcnt_reg + 4'd1;
            end
            if (cmd.out_load && cmd.out_sel == SEL_WORD)
            begin
                wcnt_reg <= '0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_load)
        begin
            frame_reg <= {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
        end
        if (cmd.store_step)
        begin
            store_mem[count_reg[AW-1:0]] <= frame_reg[{src_reg, 3'b000} +: 8];
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.close || (cmd.out_load && cmd.out_sel == SEL_WORD))
            asm_reg <= '0;
        else if (cmd.rd_capture)
            asm_reg[{wcnt_reg[2:0], 3'b000} +: 8] <= rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                SEL_SF:
                begin
                    kind <= KIND_SINGLE;
                    data_word <= sf_word;
                    valid_bytes <= low;
                    message_length <= {6'd0, low};
                    last <= 1'b1;
                    tx_id <= '0;
                    fc_status <= FC_CONTINUE;
                    fc_block_size <= '0;
                    fc_separation <= '0;
                end
                SEL_FC_CONT:
                begin
                    kind <= KIND_FLOW;
                    data_word <= '0;
                    valid_bytes <= '0;
                    message_length <= '0;
                    last <= 1'b1;
                    tx_id <= response_id_reg;
                    fc_status <= FC_CONTINUE;
                    fc_block_size <= block_size_reg;
                    fc_separation <= separation_reg;
                end
                SEL_FC_OVF:
                begin
                    kind <= KIND_FLOW;
                    data_word <= '0;
                    valid_bytes <= '0;
                    message_length <= '0;
                    last <= 1'b1;
                    tx_id <= response_id_reg;
                    fc_status <= FC_OVERFLOW;
                    fc_block_size <= '0;
                    fc_separation <= '0;
                end
                SEL_WORD:
                begin
                    kind <= KIND_WORD;
                    data_word <= asm_reg;
                    valid_bytes <= wcnt_reg;
                    message_length <= len_reg;
                    last <= (rd_ptr_reg == len_reg);
                    tx_id <= '0;
                    fc_status <= FC_CONTINUE;
                    fc_block_size <= '0;
                    fc_separation <= '0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/cantp_checker.sv =====
// Port-level checker for the reassembly block, bound to the top level.
module cantp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [63:0] data_word,
    input logic [3:0]  valid_bytes,
    input logic [9:0]  message_length,
    input logic        last
);
    import cantp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_word) && $stable(kind))
        else $error("Result beat changed while stalled.");

    a_flow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FLOW |-> data_word == 64'd0 && valid_bytes == 4'd0 && last)
        else $error("Flow-control beat carries payload or is not last.");

    a_single_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SINGLE |-> last && valid_bytes != 4'd0
            && valid_bytes <= 4'd7 && message_length == {6'd0, valid_bytes})
        else $error("Single-frame beat has a bad length.");

    a_word_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WORD && !last |-> valid_bytes == 4'd8)
        else $error("Inner message word is not full.");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_SINGLE || kind == KIND_FLOW || kind == KIND_WORD)
        else $error("Result beat has an undefined kind.");

endmodule

bind can_transport_rx_reassembly_core cantp_checker u_cantp_checker (.*);
